// ===== hw/rtl/ppsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsm_pkg
// Shared types and widths for the point to polyline segment match block.
// ----------------------------------------------------------------------------
package ppsm_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = 25;
    localparam int OPND_W  = 34;
    localparam int PROD_W  = 68;
    localparam int ACC_W   = 52;
    localparam int WIN_W   = 60;
    localparam int CA_W    = 33;
    localparam int T_W     = 17;
    localparam int FRAC_W  = 16;
    localparam int SEG_W   = 6;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vtx;

endpackage

// ===== hw/rtl/ppsm_vmem.sv =====
// ----------------------------------------------------------------------------
// ppsm_vmem
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppsm_vmem #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  ppsm_pkg::t_vtx           i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output ppsm_pkg::t_vtx           o_rdata
);
    import ppsm_pkg::*;

    t_vtx r_mem [DEPTH];
    t_vtx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/point_to_polyline_segment_match.sv =====
// ----------------------------------------------------------------------------
// point_to_polyline_segment_match
// Stores polyline vertices and matches a query point to the first segment it
// projects onto within the window and that lies less than 256 away.
//
// channel  direction  handshake          payload
// in       input      i_valid / o_stall  i_opcode i_new_line i_coord_x i_coord_y i_dir_tag
// out      output     o_valid / i_stall  o_segment_index o_param_t o_hit_x o_hit_y o_hit_dir
//
// A query fetches its first vertex, then walks the segments in order with the
// single shared multiplier, leaving a segment early when it is zero length or
// outside the window, and ends with the 16-step divider and the result load.
// Reset clears the vertex count and all control state; the vertex store is not
// cleared. The input is stalled while a query runs and while a finished result
// waits for a stalled output register.
// ----------------------------------------------------------------------------
module point_to_polyline_segment_match #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_opcode,
    input  logic                     i_new_line,
    input  ppsm_pkg::t_coord         i_coord_x,
    input  ppsm_pkg::t_coord         i_coord_y,
    input  logic                     i_dir_tag,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [ppsm_pkg::SEG_W-1:0] o_segment_index,
    output logic [ppsm_pkg::T_W-1:0] o_param_t,
    output ppsm_pkg::t_coord         o_hit_x,
    output ppsm_pkg::t_coord         o_hit_y,
    output logic                     o_hit_dir
);
    import ppsm_pkg::*;

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WAIT0 = 4'd1;
    localparam logic [3:0] S_GETA  = 4'd2;
    localparam logic [3:0] S_WAITB = 4'd3;
    localparam logic [3:0] S_GETB  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam logic [2:0] STEP_LAST = 3'd6;
    localparam logic [3:0] DIV_LAST  = 4'(FRAC_W - 1);

    logic [3:0]              r_state;
    logic [CW-1:0]           r_count;
    logic [IW-1:0]           r_addr;
    logic [IW-1:0]           r_seg;
    logic [2:0]              r_step;
    logic [3:0]              r_dcnt;
    t_coord                  r_px, r_py, r_ax, r_ay;
    logic                    r_dir;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_qx, r_qy;
    logic signed [ACC_W-1:0] r_len, r_dot, r_cross;
    logic signed [PROD_W-1:0] r_prod;
    logic [CA_W-1:0]         r_ca;
    logic                    r_small;
    logic [ACC_W-1:0]        r_rem;
    logic [T_W-1:0]          r_q;
    logic                    r_ovalid;
    logic [SEG_W-1:0]        r_oseg;
    logic [T_W-1:0]          r_ot;
    t_coord                  r_ox, r_oy;
    logic                    r_odir;

    logic                    w_acc_in;
    logic                    w_we;
    logic [IW-1:0]           w_waddr;
    logic [CW-1:0]           w_base;
    t_vtx                    w_wdata;
    t_vtx                    w_rd;
    logic signed [OPND_W-1:0] w_opa, w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [WIN_W-1:0] w_dot, w_len, w_d100, w_l101;
    logic                    w_in_win;
    logic [ACC_W-1:0]        w_ca;
    logic [ACC_W:0]          w_rem2;
    logic [ACC_W:0]          w_len2;
    logic [CW:0]             w_nxt;
    logic                    w_out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign w_acc_in = i_valid && !o_stall;

    assign w_base  = i_new_line ? '0 : r_count;
    assign w_we    = w_acc_in && !i_opcode && (w_base < CW'(MAX_VERTICES));
    assign w_waddr = w_base[IW-1:0];
    assign w_wdata = '{x: i_coord_x, y: i_coord_y};

    ppsm_vmem #(.DEPTH(MAX_VERTICES)) u_vmem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rd)
    );

    always_comb begin
        w_opa = OPND_W'(r_dx);
        w_opb = OPND_W'(r_dx);
        case (r_step)
            3'd1: begin w_opa = OPND_W'(r_dy); w_opb = OPND_W'(r_dy); end
            3'd2: begin w_opa = OPND_W'(r_qx); w_opb = OPND_W'(r_dx); end
            3'd3: begin w_opa = OPND_W'(r_qy); w_opb = OPND_W'(r_dy); end
            3'd4: begin w_opa = OPND_W'(r_dx); w_opb = OPND_W'(r_qy); end
            3'd5: begin w_opa = OPND_W'(r_dy); w_opb = OPND_W'(r_qx); end
            default: begin w_opa = OPND_W'(r_dx); w_opb = OPND_W'(r_dx); end
        endcase
        if (r_state == S_SQ) begin
            w_opa = OPND_W'({1'b0, r_ca});
            w_opb = OPND_W'({1'b0, r_ca});
        end
    end

    assign w_prod = w_opa * w_opb;

    assign w_dot    = WIN_W'(r_dot);
    assign w_len    = WIN_W'(r_len);
    assign w_d100   = (w_dot <<< 6) + (w_dot <<< 5) + (w_dot <<< 2);
    assign w_l101   = (w_len <<< 6) + (w_len <<< 5) + (w_len <<< 2) + w_len;
    assign w_in_win = (w_d100 >= -w_len) && (w_d100 <= w_l101);
    assign w_ca     = r_cross[ACC_W-1] ? ACC_W'(-r_cross) : ACC_W'(r_cross);

    assign w_rem2 = {r_rem, 1'b0};
    assign w_len2 = {1'b0, r_len};
    assign w_nxt  = (CW+1)'(r_seg) + (CW+1)'(2);
    assign w_out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_addr   <= '0;
            r_seg    <= '0;
            r_step   <= '0;
            r_dcnt   <= '0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_prod <= w_prod;
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        if (!i_opcode) begin
                            if (w_we) begin
                                r_count <= w_base + CW'(1);
                            end else begin
                                r_count <= w_base;
                            end
                        end else begin
                            r_px   <= i_coord_x;
                            r_py   <= i_coord_y;
                            r_dir  <= i_dir_tag;
                            r_addr <= '0;
                            r_seg  <= '0;
                            if (r_count >= CW'(2)) begin
                                r_state <= S_WAIT0;
                            end
                        end
                    end
                end
                S_WAIT0: r_state <= S_GETA;
                S_GETA: begin
                    r_ax    <= w_rd.x;
                    r_ay    <= w_rd.y;
                    r_addr  <= r_addr + IW'(1);
                    r_state <= S_WAITB;
                end
                S_WAITB: r_state <= S_GETB;
                S_GETB: begin
                    r_dx    <= DIFF_W'(w_rd.x) - DIFF_W'(r_ax);
                    r_dy    <= DIFF_W'(w_rd.y) - DIFF_W'(r_ay);
                    r_qx    <= DIFF_W'(r_px) - DIFF_W'(r_ax);
                    r_qy    <= DIFF_W'(r_py) - DIFF_W'(r_ay);
                    r_ax    <= w_rd.x;
                    r_ay    <= w_rd.y;
                    r_addr  <= r_addr + IW'(1);
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: begin
                            if (r_dx == '0 && r_dy == '0) begin
                                r_state <= S_NEXT;
                            end
                        end
                        3'd1: r_len   <= ACC_W'(r_prod);
                        3'd2: r_len   <= r_len + ACC_W'(r_prod);
                        3'd3: r_dot   <= ACC_W'(r_prod);
                        3'd4: r_dot   <= r_dot + ACC_W'(r_prod);
                        3'd5: r_cross <= ACC_W'(r_prod);
                        default: begin
                            r_cross <= r_cross - ACC_W'(r_prod);
                            r_state <= S_CHK;
                        end
                    endcase
                    if (r_step == STEP_LAST) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_ca    <= w_ca[CA_W-1:0];
                    r_small <= (w_ca[ACC_W-1:CA_W] == '0);
                    r_state <= w_in_win ? S_SQ : S_NEXT;
                end
                S_SQ: begin
                    r_state <= r_small ? S_CMP : S_NEXT;
                end
                S_CMP: begin
                    if (r_prod < PROD_W'({r_len, 16'd0})) begin
                        r_dcnt <= '0;
                        r_rem  <= r_dot;
                        r_q    <= '0;
                        if (r_dot[ACC_W-1] || (r_dot == '0)) begin
                            r_state <= S_FIN;
                        end else if (r_dot >= r_len) begin
                            r_q     <= T_W'(1) << FRAC_W;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (w_nxt < (CW+1)'(r_count)) begin
                        r_seg   <= r_seg + IW'(1);
                        r_state <= S_WAITB;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 4'd1;
                    if (w_rem2 >= w_len2) begin
                        r_rem <= ACC_W'(w_rem2 - w_len2);
                        r_q   <= {r_q[T_W-2:0], 1'b1};
                    end else begin
                        r_rem <= ACC_W'(w_rem2);
                        r_q   <= {r_q[T_W-2:0], 1'b0};
                    end
                    if (r_dcnt == DIV_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_oseg   <= SEG_W'(r_seg);
                        r_ot     <= r_q;
                        r_ox     <= r_px;
                        r_oy     <= r_py;
                        r_odir   <= r_dir;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_segment_index = r_oseg;
    assign o_param_t       = r_ot;
    assign o_hit_x         = r_ox;
    assign o_hit_y         = r_oy;
    assign o_hit_dir       = r_odir;

endmodule

// ===== test/point_to_polyline_segment_match_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_polyline_segment_match_tb
// Loads polylines and sends query points, predicts the first matching segment
// of each query and checks every result field; idles, stalls and a long
// output hold-off vary along the run.
// ----------------------------------------------------------------------------
module point_to_polyline_segment_match_tb;
    import ppsm_pkg::*;

    localparam int MAX_VTX    = 64;
    localparam int WD_LIMIT   = 6000;
    localparam int DRAIN_CYC  = 1200;
    localparam int HOLD_CYC   = 500;
    localparam bit OP_APPEND  = 1'b0;
    localparam bit OP_QUERY   = 1'b1;

    typedef struct {
        bit     op;
        bit     nl;
        t_coord x;
        t_coord y;
        bit     dir;
    } t_item;

    typedef struct {
        logic [SEG_W-1:0] seg;
        logic [T_W-1:0]   t;
        t_coord           x;
        t_coord           y;
        logic             dir;
    } t_hit;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_opcode = 0;
    logic i_new_line = 0;
    t_coord i_coord_x = '0;
    t_coord i_coord_y = '0;
    logic i_dir_tag = 0;
    logic i_stall = 0;
    logic o_stall, o_valid, o_hit_dir;
    logic [SEG_W-1:0] o_segment_index;
    logic [T_W-1:0] o_param_t;
    t_coord o_hit_x, o_hit_y;

    t_item pending_items[$];
    t_hit  expected_hits[$];
    t_coord vtx_x[MAX_VTX];
    t_coord vtx_y[MAX_VTX];
    int vtx_count = 0;
    int errors = 0, sent = 0, queries = 0, hits = 0;
    int idle_cycles = 0, hold_left = 0;
    bit hold_done = 0;
    int send_idle_pct, recv_stall_pct;

    point_to_polyline_segment_match u_top (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic bit find_segment(t_item it, output t_hit h);
        longint ax, ay, dx, dy, qx, qy, len, dot, crs;
        logic signed [127:0] cw, lw;
        h = '{default: '0};
        for (int i = 0; i + 1 < vtx_count; i++) begin
            ax = vtx_x[i];
            ay = vtx_y[i];
            dx = longint'(vtx_x[i+1]) - ax;
            dy = longint'(vtx_y[i+1]) - ay;
            qx = longint'(it.x) - ax;
            qy = longint'(it.y) - ay;
            if (dx == 0 && dy == 0) continue;
            len = dx * dx + dy * dy;
            dot = qx * dx + qy * dy;
            if (dot * 100 < -len || dot * 100 > len * 101) continue;
            crs = dx * qy - dy * qx;
            cw = crs;
            lw = len;
            if (cw * cw < lw * 65536) begin
                h.seg = i[SEG_W-1:0];
                if (dot <= 0) h.t = '0;
                else if (dot >= len) h.t = 17'd65536;
                else h.t = T_W'((lw * 65536 - (lw - dot) * 65536 + 0) / lw);
                h.x = it.x;
                h.y = it.y;
                h.dir = it.dir;
                return 1;
            end
        end
        return 0;
    endfunction

    task automatic predict_item(t_item it);
        t_hit h;
        if (it.op == OP_APPEND) begin
            if (it.nl) vtx_count = 0;
            if (vtx_count < MAX_VTX) begin
                vtx_x[vtx_count] = it.x;
                vtx_y[vtx_count] = it.y;
                vtx_count++;
            end
        end else begin
            queries++;
            if (find_segment(it, h)) begin
                expected_hits = {expected_hits, h};
                hits++;
            end
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint exp);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                it = '{i_opcode, i_new_line, i_coord_x, i_coord_y, i_dir_tag};
                predict_item(it);
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    it = pending_items.pop_front();
                    i_valid <= 1;
                    i_opcode <= it.op;
                    i_new_line <= it.nl;
                    i_coord_x <= it.x;
                    i_coord_y <= it.y;
                    i_dir_tag <= it.dir;
                    sent++;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_hit e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result, segment", o_segment_index, -1);
                end else begin
                    e = expected_hits.pop_front();
                    if (o_segment_index !== e.seg) report_mismatch("segment_index", o_segment_index, e.seg);
                    if (o_param_t !== e.t) report_mismatch("param_t", o_param_t, e.t);
                    if (o_hit_x !== e.x) report_mismatch("hit_x", o_hit_x, e.x);
                    if (o_hit_y !== e.y) report_mismatch("hit_y", o_hit_y, e.y);
                    if (o_hit_dir !== e.dir) report_mismatch("hit_dir", o_hit_dir, e.dir);
                end
            end
            i_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // hold the output for a long stretch once, mid run
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent >= 320) begin
            hold_left <= HOLD_CYC;
            hold_done <= 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WD_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        case (sent / 110)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 57; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 57; end
            3: begin send_idle_pct <= 37; recv_stall_pct <= 37; end
            default: begin
                send_idle_pct <= $urandom_range(0, 40);
                recv_stall_pct <= $urandom_range(0, 40);
            end
        endcase
    end

    task automatic add(bit op, bit nl, int x, int y, bit dir);
        t_item it;
        it = '{op, nl, t_coord'(x), t_coord'(y), dir};
        pending_items = {pending_items, it};
    endtask

    task automatic add_polyline_and_queries(int n, int step);
        int px[$], py[$];
        int x, y, k, s, dx, dy, ox, oy;
        x = $urandom_range(0, 4000000) - 2000000;
        y = $urandom_range(0, 4000000) - 2000000;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) != 0 || i == 0) begin
                x += $urandom_range(0, 2 * step) - step;
                y += $urandom_range(0, 2 * step) - step;
            end
            px = {px, x};
            py = {py, y};
            add(OP_APPEND, i == 0 ? 1'b1 : 1'($urandom_range(0, 29) == 0), x, y,
                1'($urandom));
        end
        repeat ($urandom_range(2, 6)) begin
            s = $urandom_range(0, n - 2);
            dx = px[s+1] - px[s];
            dy = py[s+1] - py[s];
            k = $urandom_range(0, 106) - 3;
            ox = $urandom_range(0, 600);
            oy = $urandom_range(0, 600);
            add(OP_QUERY, 1'($urandom), px[s] + dx * k / 100 + ox - 300,
                py[s] + dy * k / 100 + oy - 300, 1'($urandom));
        end
    endtask

    initial begin
        add(OP_QUERY, 0, 0, 0, 1);
        add(OP_APPEND, 1, 0, 0, 0);
        add(OP_QUERY, 0, 0, 0, 0);
        add(OP_APPEND, 0, 0, 0, 1);
        add(OP_APPEND, 0, 2560, 0, 0);
        add(OP_QUERY, 0, 1280, 100, 1);
        add(OP_QUERY, 1, 1280, -100, 0);
        add(OP_QUERY, 0, -20, 0, 1);
        add(OP_QUERY, 0, -30, 0, 1);
        add(OP_QUERY, 0, 2580, 0, 0);
        add(OP_QUERY, 0, 2590, 0, 0);
        add(OP_QUERY, 0, 1280, 256, 1);
        add(OP_APPEND, 1, -8388608, -8388608, 0);
        add(OP_APPEND, 0, 8388607, 8388607, 1);
        add(OP_QUERY, 0, 0, 0, 1);
        add(OP_QUERY, 0, 8388607, -8388608, 0);
        add(OP_QUERY, 0, -8388608, -8388608, 1);
        for (int i = 0; i < 66; i++) add(OP_APPEND, i == 0, i * 256, i >= 64 ? 5000 : 0, 0);
        add(OP_QUERY, 0, 62 * 256 + 128, 10, 1);
        add(OP_QUERY, 0, 64 * 256 + 128, 5000, 0);
        add(OP_APPEND, 1, 100, 100, 0);
        add(OP_APPEND, 0, 100, 100, 0);
        add(OP_QUERY, 0, 100, 100, 1);
        while (pending_items.size() < 550) begin
            case ($urandom_range(0, 19))
                0: add_polyline_and_queries($urandom_range(40, 66), 2000);
                1, 2, 3: add(1'($urandom), 1'($urandom), $urandom, $urandom, 1'($urandom));
                4: add(OP_APPEND, 1'($urandom), $urandom, $urandom, 1'($urandom));
                default: add_polyline_and_queries($urandom_range(2, 7),
                                                  $urandom_range(0, 3) == 0 ? 200000 : 3000);
            endcase
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_hits.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (expected_hits.size() > 0) report_mismatch("results left over", expected_hits.size(), 0);
        $display("run covered %0d items, %0d queries and %0d matched segments", sent, queries,
                 hits);
        $display("with empty, short, full and extreme polylines under idling and stalls");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ppsm_pkg.sv
hw/rtl/ppsm_vmem.sv
hw/rtl/point_to_polyline_segment_match.sv
test/point_to_polyline_segment_match_tb.sv
